// ===== rtl/core/qpm_pkg.sv =====
`timescale 1ns / 1ps

package qpm_pkg;

    localparam int FRC_W   = 32;   // motor force, signed Q16.16
    localparam int K_W     = 32;   // half inverse lever, unsigned Q16.16
    localparam int COEF_W  = 24;   // inverse thrust coefficient
    localparam int SPEED_W = 27;   // motor speed, unsigned Q19.8
    localparam int RAD_W   = 56;   // radicand, force magnitude times coefficient
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int SUM_W   = 51;   // nominal plus scaled torque before clamping
    localparam int PROD_W  = 65;   // signed torque times unsigned k
    localparam int NMOT    = 4;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_HALF_INV_LEVER = 2'd0;
    localparam logic [IDX_W-1:0] REG_INV_THRUST_COEF = 2'd1;

    localparam logic [K_W-1:0]    K_RESET    = 32'd655360;
    localparam logic [COEF_W-1:0] COEF_RESET = 24'd2083333;

    // One mixed command as it leaves the front end
    typedef struct packed {
        logic [NMOT-1:0][FRC_W-1:0] frc;
    } mix_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_st_t;

    function automatic logic [FRC_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sd2147483647);
        lo = -SUM_W'(64'sd2147483648);
        if (v > hi) begin
            sat32 = 32'h7fff_ffff;
        end else if (v < lo) begin
            sat32 = 32'h8000_0000;
        end else begin
            sat32 = v[FRC_W-1:0];
        end
    endfunction

    // One restoring square-root digit: bring down two radicand bits
    function automatic root_st_t root_step(input root_st_t cur, input logic [1:0] bits);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        root_st_t nxt;
        r = {cur.rem[REM_W-3:0], bits};
        t = {1'b0, cur.root, 2'b01};
        if (r >= t) begin
            nxt.rem  = r - t;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            nxt.rem  = r;
            nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return nxt;
    endfunction

endpackage

// ===== rtl/core/qpm_front.sv =====
`timescale 1ns / 1ps

module qpm_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [31:0]         s_thrust_z,
    input  logic signed [31:0]         s_roll_torque,
    input  logic signed [31:0]         s_pitch_torque,
    input  logic [qpm_pkg::K_W-1:0]    half_inverse_lever,
    output logic                       push,
    output qpm_pkg::mix_t              push_data,
    input  logic                       q_full
);

    logic                              v1_reg, v2_reg;
    logic signed [30:0]                nom1_reg;
    logic signed [qpm_pkg::PROD_W-1:0] py1_reg, px1_reg;
    qpm_pkg::mix_t                     mix2_reg, mix2_next;
    logic                              adv;
    logic signed [qpm_pkg::SUM_W-1:0]  nom_x, ty_x, tx_x;

    assign adv       = !v2_reg || !q_full;
    assign s_ready   = adv;
    assign push      = v2_reg && !q_full;
    assign push_data = mix2_reg;

    // floor(torque * k / 2^16) is an arithmetic shift of the product
    always_comb begin
        nom_x = qpm_pkg::SUM_W'(nom1_reg);
        ty_x  = qpm_pkg::SUM_W'($signed(py1_reg[qpm_pkg::PROD_W-1:16]));
        tx_x  = qpm_pkg::SUM_W'($signed(px1_reg[qpm_pkg::PROD_W-1:16]));
        mix2_next.frc[0] = qpm_pkg::sat32(nom_x + ty_x);
        mix2_next.frc[1] = qpm_pkg::sat32(nom_x + tx_x);
        mix2_next.frc[2] = qpm_pkg::sat32(nom_x - ty_x);
        mix2_next.frc[3] = qpm_pkg::sat32(nom_x - tx_x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid && (s_thrust_z > 32'sd0);
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nom1_reg <= 31'(s_thrust_z >>> 2);
            py1_reg  <= s_pitch_torque * $signed({1'b0, half_inverse_lever});
            px1_reg  <= s_roll_torque * $signed({1'b0, half_inverse_lever});
            mix2_reg <= mix2_next;
        end
    end

endmodule

// ===== rtl/core/qpm_queue.sv =====
`timescale 1ns / 1ps

module qpm_queue #(
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  qpm_pkg::mix_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output qpm_pkg::mix_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qpm_pkg::mix_t   mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/qpm_back.sv =====
`timescale 1ns / 1ps

module qpm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  qpm_pkg::mix_t                 q_data,
    output logic                          pop,
    input  logic [qpm_pkg::COEF_W-1:0]    inverse_thrust_coefficient,
    output logic                          m_valid,
    input  logic                          m_ready,
    output qpm_pkg::mix_t                 m_mix,
    output logic [qpm_pkg::NMOT-1:0][qpm_pkg::SPEED_W-1:0] m_speed,
    output logic [qpm_pkg::NMOT-1:0]      m_mask
);

    localparam int NS = qpm_pkg::ROOT_W;

    logic                                 adv;
    logic [NS:0]                          v_reg;
    qpm_pkg::mix_t                        mix_reg  [NS+1];
    logic [qpm_pkg::NMOT-1:0]             mask_reg [NS+1];
    logic [qpm_pkg::NMOT-1:0][qpm_pkg::RAD_W-1:0] rad_reg [NS+1];
    qpm_pkg::root_st_t [qpm_pkg::NMOT-1:0]        st_reg  [NS+1];

    assign adv = !v_reg[NS] || m_ready;
    assign pop = q_not_empty && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-1:0], q_not_empty};
        end
    end

    // Stage 0: radicand = force * coefficient, negative forces flagged
    always_ff @(posedge aclk) begin
        if (adv) begin
            mix_reg[0] <= q_data;
            for (int i = 0; i < qpm_pkg::NMOT; i++) begin
                mask_reg[0][i] <= q_data.frc[i][qpm_pkg::FRC_W-1];
                rad_reg[0][i]  <= q_data.frc[i][qpm_pkg::FRC_W-1] ? '0 :
                    qpm_pkg::RAD_W'(q_data.frc[i][qpm_pkg::FRC_W-2:0]) *
                    qpm_pkg::RAD_W'(inverse_thrust_coefficient);
                st_reg[0][i]   <= '0;
            end
        end
    end

    // One root digit per stage, radicand consumed from the top
    for (genvar s = 0; s < NS; s++) begin : g_root
        always_ff @(posedge aclk) begin
            if (adv) begin
                mix_reg[s+1]  <= mix_reg[s];
                mask_reg[s+1] <= mask_reg[s];
                for (int i = 0; i < qpm_pkg::NMOT; i++) begin
                    st_reg[s+1][i]  <= qpm_pkg::root_step(st_reg[s][i],
                        rad_reg[s][i][qpm_pkg::RAD_W-1 -: 2]);
                    rad_reg[s+1][i] <= {rad_reg[s][i][qpm_pkg::RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign m_valid = v_reg[NS];
    assign m_mix   = mix_reg[NS];
    assign m_mask  = mask_reg[NS];

    always_comb begin
        for (int i = 0; i < qpm_pkg::NMOT; i++) begin
            m_speed[i] = st_reg[NS][i].root[qpm_pkg::ROOT_W-1] ? '1 :
                         st_reg[NS][i].root[qpm_pkg::SPEED_W-1:0];
        end
    end

endmodule

// ===== rtl/core/quad_plus_mixer_with_speed_root.sv =====
`timescale 1ns / 1ps
// Pipeline: 2 front stages, 1 in the queue and 29 in the back end (product
// stage plus 28 root digits). Throughput: one request per cycle unless m_ready stalls;
// the 28-stage root pipeline takes a new radicand each cycle while it advances.
// Requests with thrust zero or negative are accepted and dropped in the front end.
// Reset (aresetn low, synchronous) empties all stages and the queue and loads
// the register defaults (k = 10.0, coefficient 2083333).
module quad_plus_mixer_with_speed_root #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_thrust_z,
    input  logic signed [31:0]  s_roll_torque,
    input  logic signed [31:0]  s_pitch_torque,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_force_front_left,
    output logic signed [31:0]  m_force_front_right,
    output logic signed [31:0]  m_force_back_right,
    output logic signed [31:0]  m_force_back_left,
    output logic [26:0]         m_speed_front_left,
    output logic [26:0]         m_speed_front_right,
    output logic [26:0]         m_speed_back_right,
    output logic [26:0]         m_speed_back_left,
    output logic [3:0]          m_negative_force_mask
);

    logic [qpm_pkg::K_W-1:0]    k_reg;
    logic [qpm_pkg::COEF_W-1:0] coef_reg;

    logic          push, q_full, q_pop, q_not_empty;
    qpm_pkg::mix_t push_data, q_data, out_mix;
    logic [qpm_pkg::NMOT-1:0][qpm_pkg::SPEED_W-1:0] out_speed;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= qpm_pkg::K_RESET;
            coef_reg <= qpm_pkg::COEF_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                qpm_pkg::REG_HALF_INV_LEVER:  k_reg    <= cfg_data;
                qpm_pkg::REG_INV_THRUST_COEF: coef_reg <= cfg_data[qpm_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: thrust split, torque scaling, force clamping
    qpm_front u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_thrust_z         (s_thrust_z),
        .s_roll_torque      (s_roll_torque),
        .s_pitch_torque     (s_pitch_torque),
        .half_inverse_lever (k_reg),
        .push               (push),
        .push_data          (push_data),
        .q_full             (q_full)
    );

    // Queue decouples front stalls from output back-pressure
    qpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    // Back: speed = isqrt(force * coefficient), one digit per stage
    qpm_back u_back (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .q_not_empty                (q_not_empty),
        .q_data                     (q_data),
        .pop                        (q_pop),
        .inverse_thrust_coefficient (coef_reg),
        .m_valid                    (m_valid),
        .m_ready                    (m_ready),
        .m_mix                      (out_mix),
        .m_speed                    (out_speed),
        .m_mask                     (m_negative_force_mask)
    );

    assign m_force_front_left  = out_mix.frc[0];
    assign m_force_front_right = out_mix.frc[1];
    assign m_force_back_right  = out_mix.frc[2];
    assign m_force_back_left   = out_mix.frc[3];
    assign m_speed_front_left  = out_speed[0];
    assign m_speed_front_right = out_speed[1];
    assign m_speed_back_right  = out_speed[2];
    assign m_speed_back_left   = out_speed[3];

endmodule
